FILE: sv/lpbp_pkg.sv
`default_nettype none

package lpbp_pkg;

  localparam int unsigned TAG_W   = 32;
  localparam logic [7:0]  PIN_MAX = 8'd255;

  typedef enum logic [2:0] {
    ACT_GET    = 3'd0,
    ACT_ALLOC  = 3'd1,
    ACT_DIRTY  = 3'd2,
    ACT_UNPIN  = 3'd3,
    ACT_FORCE  = 3'd4,
    ACT_FLUSH  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    KIND_FINAL = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WB    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PINNED    = 3'd1,
    ST_ALREADY   = 3'd2,
    ST_NOT_BUF   = 3'd3,
    ST_UNPINNED  = 3'd4,
    ST_NO_BUFFER = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WBV,
    S_FILL,
    S_FIN,
    S_FSEEK,
    S_FCHK
  } fsm_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  file_id;
    logic [23:0] page_number;
    logic        multiple_pins;
    logic        whole_file;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_file_id;
    logic [23:0] out_page_number;
    logic [3:0]  slot;
    logic [2:0]  status;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/lpbp_ram.sv
`default_nettype none

module lpbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/lru_page_buffer_pool_unit.sv
// page buffer pool with lru replacement and pin counts
// the tag ram is scanned one slot a cycle, then the decide state acts on the result
// get/allocate on a miss may write back a dirty victim, then fill; mark dirty/unpin end at decide
// force/flush then walk the valid slots in mru order through the seek and check states
// one result transfer per cycle at most; the receiver cannot stall, results are never held
// reset: all slots invalid, pins/dirty/ranks zero, free stack holds slot i at position i
`default_nettype none

module lru_page_buffer_pool_unit
  import lpbp_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output res_t      res_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = SW + 1;
  localparam logic [CW-1:0] NCNT = CW'(NUM_SLOTS);

  // control state
  fsm_e          state_q, state_d;
  req_t          req_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          hit_q, hit_d;
  logic [SW-1:0] hit_slot_q, hit_slot_d;
  logic          vic_q, vic_d;
  logic [SW-1:0] vic_slot_q, vic_slot_d;
  logic [SW-1:0] tgt_q, tgt_d;
  logic          warn_q, warn_d;

  // per slot bookkeeping
  logic          valid_q [NUM_SLOTS];
  logic          valid_d [NUM_SLOTS];
  logic [7:0]    pins_q  [NUM_SLOTS];
  logic [7:0]    pins_d  [NUM_SLOTS];
  logic          dirty_q [NUM_SLOTS];
  logic          dirty_d [NUM_SLOTS];
  logic [SW-1:0] rank_q  [NUM_SLOTS];
  logic [SW-1:0] rank_d  [NUM_SLOTS];
  logic [SW-1:0] fstk_q  [NUM_SLOTS];
  logic [SW-1:0] fstk_d  [NUM_SLOTS];
  logic [CW-1:0] fcnt_q, fcnt_d;

  // result register
  logic res_valid_d;
  res_t res_d;

  // tag ram
  logic             ram_we;
  logic [SW-1:0]    ram_raddr;
  logic [TAG_W-1:0] ram_rdata;

  // bookkeeping strobes from the sequencer
  logic          mru_en;
  logic [SW-1:0] mru_s;
  logic [CW-1:0] mru_thr;
  logic          unl_en;
  logic          pin1_en, pinc_en, pdec_en, dset_en, dclr_en;
  logic [SW-1:0] op_s;
  logic          pop_en, push_en;

  // scan helpers
  logic [SW-1:0] scan_prev;
  logic          scan_match;
  logic          fnd;
  logic [SW-1:0] fnd_slot;
  logic          file_eq, page_eq;

  lpbp_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt_q),
    .wdata_i ({req_q.file_id, req_q.page_number}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign scan_prev   = SW'(cnt_q - CW'(1));
  assign scan_match  = valid_q[scan_prev]
                       && (ram_rdata == {req_q.file_id, req_q.page_number});
  assign file_eq     = (ram_rdata[TAG_W-1 -: 8] == req_q.file_id);
  assign page_eq     = (ram_rdata[23:0] == req_q.page_number);

  // slot holding the rank under the walk pointer, ranks are unique among valid slots
  always_comb begin
    fnd      = 1'b0;
    fnd_slot = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (valid_q[i] && ({1'b0, rank_q[i]} == cnt_q)) begin
        fnd      = 1'b1;
        fnd_slot = SW'(i);
      end
    end
  end

  // tag ram read address
  always_comb begin
    case (state_q)
      S_SCAN:   ram_raddr = cnt_q[SW-1:0];
      S_DECIDE: ram_raddr = vic_slot_q;
      S_FSEEK:  ram_raddr = fnd_slot;
      default:  ram_raddr = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_q == NCNT) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        case (req_q.action)
          ACT_GET, ACT_ALLOC: begin
            if (!hit_q) begin
              if (fcnt_q != '0) begin
                state_d = S_FILL;
              end else if (vic_q) begin
                state_d = dirty_q[vic_slot_q] ? S_WBV : S_FILL;
              end
            end
          end
          ACT_FORCE, ACT_FLUSH: state_d = S_FSEEK;
          default: state_d = S_IDLE;
        endcase
      end
      S_WBV:   state_d = S_FILL;
      S_FILL:  state_d = (req_q.action == ACT_GET) ? S_FIN : S_IDLE;
      S_FIN:   state_d = S_IDLE;
      S_FSEEK: state_d = fnd ? S_FCHK : S_IDLE;
      S_FCHK:  state_d = S_FSEEK;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: results and bookkeeping strobes
  always_comb begin
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    vic_d       = vic_q;
    vic_slot_d  = vic_slot_q;
    tgt_d       = tgt_q;
    warn_d      = warn_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    ram_we      = 1'b0;
    mru_en      = 1'b0;
    mru_s       = '0;
    mru_thr     = '0;
    unl_en      = 1'b0;
    pin1_en     = 1'b0;
    pinc_en     = 1'b0;
    pdec_en     = 1'b0;
    dset_en     = 1'b0;
    dclr_en     = 1'b0;
    op_s        = '0;
    pop_en      = 1'b0;
    push_en     = 1'b0;
    res_d.last  = 1'b1;
    res_d.kind  = KIND_FINAL;
    res_d.status = ST_OK;

    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        hit_d = 1'b0;
        vic_d = 1'b0;
      end

      S_SCAN: begin
        if (cnt_q != NCNT) cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0) begin
          // lowest matching slot wins
          if (scan_match && !hit_q) begin
            hit_d      = 1'b1;
            hit_slot_d = scan_prev;
          end
          // lru candidate: oldest unpinned valid slot
          if (valid_q[scan_prev] && (pins_q[scan_prev] == '0)
              && (!vic_q || (rank_q[scan_prev] > rank_q[vic_slot_q]))) begin
            vic_d      = 1'b1;
            vic_slot_d = scan_prev;
          end
        end
      end

      S_DECIDE: begin
        case (req_q.action)
          ACT_GET, ACT_ALLOC: begin
            if (hit_q) begin
              res_valid_d = 1'b1;
              res_d.slot  = 4'({{4{1'b0}}, hit_slot_q});
              if (req_q.action == ACT_ALLOC) begin
                res_d.status = ST_ALREADY;
              end else if (!req_q.multiple_pins && (pins_q[hit_slot_q] != '0)) begin
                res_d.status = ST_PINNED;
              end else begin
                pinc_en = 1'b1;
                op_s    = hit_slot_q;
                mru_en  = 1'b1;
                mru_s   = hit_slot_q;
                mru_thr = {1'b0, rank_q[hit_slot_q]};
              end
            end else if (fcnt_q != '0) begin
              // free slot goes to the mru head, every valid rank ages
              pop_en  = 1'b1;
              tgt_d   = fstk_q[0];
              mru_en  = 1'b1;
              mru_s   = fstk_q[0];
              mru_thr = NCNT;
            end else if (!vic_q) begin
              res_valid_d  = 1'b1;
              res_d.status = ST_NO_BUFFER;
            end else if (!dirty_q[vic_slot_q]) begin
              tgt_d   = vic_slot_q;
              mru_en  = 1'b1;
              mru_s   = vic_slot_q;
              mru_thr = {1'b0, rank_q[vic_slot_q]};
            end
          end
          ACT_DIRTY, ACT_UNPIN: begin
            res_valid_d = 1'b1;
            if (!hit_q) begin
              res_d.status = ST_NOT_BUF;
            end else begin
              res_d.slot = 4'({{4{1'b0}}, hit_slot_q});
              op_s       = hit_slot_q;
              mru_s      = hit_slot_q;
              mru_thr    = {1'b0, rank_q[hit_slot_q]};
              if (pins_q[hit_slot_q] == '0) begin
                res_d.status = ST_UNPINNED;
              end else if (req_q.action == ACT_DIRTY) begin
                dset_en = 1'b1;
                mru_en  = 1'b1;
              end else begin
                pdec_en = 1'b1;
                mru_en  = (pins_q[hit_slot_q] == 8'd1);
              end
            end
          end
          ACT_FORCE, ACT_FLUSH: begin
            cnt_d  = '0;
            warn_d = 1'b0;
          end
          default: begin
            res_valid_d = 1'b1;
          end
        endcase
      end

      S_WBV: begin
        // dirty victim: old tag goes out before the slot is reused
        res_valid_d           = 1'b1;
        res_d.kind            = KIND_WB;
        res_d.last            = 1'b0;
        res_d.out_file_id     = ram_rdata[TAG_W-1 -: 8];
        res_d.out_page_number = ram_rdata[23:0];
        res_d.slot            = 4'({{4{1'b0}}, vic_slot_q});
        dclr_en = 1'b1;
        op_s    = vic_slot_q;
        tgt_d   = vic_slot_q;
        mru_en  = 1'b1;
        mru_s   = vic_slot_q;
        mru_thr = {1'b0, rank_q[vic_slot_q]};
      end

      S_FILL: begin
        ram_we      = 1'b1;
        pin1_en     = 1'b1;
        op_s        = tgt_q;
        res_valid_d = 1'b1;
        res_d.slot  = 4'({{4{1'b0}}, tgt_q});
        if (req_q.action == ACT_GET) begin
          res_d.kind            = KIND_READ;
          res_d.last            = 1'b0;
          res_d.out_file_id     = req_q.file_id;
          res_d.out_page_number = req_q.page_number;
        end
      end

      S_FIN: begin
        res_valid_d = 1'b1;
        res_d.slot  = 4'({{4{1'b0}}, tgt_q});
      end

      S_FSEEK: begin
        tgt_d = fnd_slot;
        if (!fnd) begin
          res_valid_d  = 1'b1;
          res_d.status = warn_q ? ST_PINNED : ST_OK;
        end
      end

      S_FCHK: begin
        op_s                  = tgt_q;
        res_d.kind            = KIND_WB;
        res_d.last            = 1'b0;
        res_d.out_file_id     = req_q.file_id;
        res_d.out_page_number = ram_rdata[23:0];
        res_d.slot            = 4'({{4{1'b0}}, tgt_q});
        cnt_d                 = cnt_q + CW'(1);
        if (file_eq) begin
          if (req_q.action == ACT_FORCE) begin
            if ((req_q.whole_file || page_eq) && dirty_q[tgt_q]) begin
              res_valid_d = 1'b1;
              dclr_en     = 1'b1;
            end
          end else if (pins_q[tgt_q] != '0) begin
            warn_d = 1'b1;
          end else begin
            // freed slot: older slots move up one rank, so the pointer stays
            res_valid_d = dirty_q[tgt_q];
            dclr_en     = 1'b1;
            unl_en      = 1'b1;
            push_en     = 1'b1;
            cnt_d       = cnt_q;
          end
        end
      end

      default: begin
      end
    endcase
  end

  // bookkeeping update
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      valid_d[i] = valid_q[i];
      pins_d[i]  = pins_q[i];
      dirty_d[i] = dirty_q[i];
      rank_d[i]  = rank_q[i];
      fstk_d[i]  = fstk_q[i];
    end
    fcnt_d = fcnt_q;

    if (mru_en) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if ((SW'(i) != mru_s) && valid_q[i] && ({1'b0, rank_q[i]} < mru_thr)) begin
          rank_d[i] = rank_q[i] + SW'(1);
        end
      end
      rank_d[mru_s]  = '0;
      valid_d[mru_s] = 1'b1;
    end

    if (unl_en) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if ((SW'(i) != op_s) && valid_q[i] && (rank_q[i] > rank_q[op_s])) begin
          rank_d[i] = rank_q[i] - SW'(1);
        end
      end
      valid_d[op_s] = 1'b0;
    end

    if (pin1_en) begin
      pins_d[op_s]  = 8'd1;
      dirty_d[op_s] = 1'b0;
    end
    if (pinc_en && (pins_q[op_s] != PIN_MAX)) pins_d[op_s] = pins_q[op_s] + 8'd1;
    if (pdec_en) pins_d[op_s] = pins_q[op_s] - 8'd1;
    if (dset_en) dirty_d[op_s] = 1'b1;
    if (dclr_en) dirty_d[op_s] = 1'b0;

    if (pop_en) begin
      for (int k = 0; k < NUM_SLOTS - 1; k++) begin
        fstk_d[k] = fstk_q[k+1];
      end
      fcnt_d = fcnt_q - CW'(1);
    end
    if (push_en) begin
      for (int k = 1; k < NUM_SLOTS; k++) begin
        fstk_d[k] = fstk_q[k-1];
      end
      fstk_d[0] = op_s;
      fcnt_d    = fcnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      hit_slot_q  <= '0;
      vic_q       <= 1'b0;
      vic_slot_q  <= '0;
      tgt_q       <= '0;
      warn_q      <= 1'b0;
      fcnt_q      <= NCNT;
      res_valid_o <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        valid_q[i] <= 1'b0;
        pins_q[i]  <= '0;
        dirty_q[i] <= 1'b0;
        rank_q[i]  <= '0;
        fstk_q[i]  <= SW'(i);
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      hit_slot_q  <= hit_slot_d;
      vic_q       <= vic_d;
      vic_slot_q  <= vic_slot_d;
      tgt_q       <= tgt_d;
      warn_q      <= warn_d;
      fcnt_q      <= fcnt_d;
      res_valid_o <= res_valid_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        valid_q[i] <= valid_d[i];
        pins_q[i]  <= pins_d[i];
        dirty_q[i] <= dirty_d[i];
        rank_q[i]  <= rank_d[i];
        fstk_q[i]  <= fstk_d[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_o <= res_d;
    if ((state_q == S_IDLE) && start_i) begin
      req_q <= req_i;
    end
  end

endmodule

`default_nettype wire
